>>> design/lz_token_bitstream_encoder_assert.svh
// assertion helpers used by the encoder back end
`ifndef LZ_TOKEN_BITSTREAM_ENCODER_ASSERT_SVH
`define LZ_TOKEN_BITSTREAM_ENCODER_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define LZTBE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LZTBE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/lztbe_pkg.sv
package lztbe_pkg;

  localparam logic [1:0] ACT_LITERAL = 2'd0;
  localparam logic [1:0] ACT_MATCH   = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam int HELD_DEPTH = 8;

  // bits of the end marker: leading one, sixteen ones, closing zero
  localparam logic [5:0] FIN_TOTAL = 6'd18;
  localparam logic [3:0] FIN_ONES_LAST = 4'd15;

  typedef enum logic [1:0] {
    K_LIT,
    K_MATCH,
    K_FIN
  } kind_t;

  // one classified token as the back end walks it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;      // data byte that follows the first flag bit
    logic        long_off;  // offset-1 above 127
    logic [3:0]  off_hi;    // bits 10..7 of offset-1
    logic [15:0] val;       // low bits of gamma value
    logic        n_zero;    // gamma prefix length is zero
    logic [3:0]  nm1;       // gamma prefix length minus one
    logic [5:0]  total;     // flag bits in this token
  } desc_t;

endpackage

>>> design/lz_token_bitstream_encoder.sv
// a token is written into the queue and loaded from there by the sequencer while it is idle;
//   its first flag bit follows in the bit state, after the release of any full flag byte
// the bit-serial sequencer finishes each token's flag bits, and any byte releases that fall
//   mid-token, before it loads the next token; a stalled output holds up a release
// a two-entry token queue lets the input run ahead of the sequencer
// reset clears flag count, held count, queue and output valid; held bytes are not cleared
module lz_token_bitstream_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  literal_byte,
  input  logic [11:0] match_offset,
  input  logic [15:0] match_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end
);

  logic             q_valid;
  lztbe_pkg::desc_t q_head;
  logic             pop;

  lztbe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .literal_byte (literal_byte),
    .match_offset (match_offset),
    .match_length (match_length),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop)
  );

  lztbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule

>>> design/lztbe_front.sv
module lztbe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [7:0]          literal_byte,
  input  logic [11:0]         match_offset,
  input  logic [15:0]         match_length,
  output logic                q_valid,
  output lztbe_pkg::desc_t    q_head,
  input  logic                pop
);

  logic [11:0]      d;
  logic [15:0]      l;
  logic [16:0]      w;
  logic [4:0]       n;
  logic             long_off;
  lztbe_pkg::desc_t dec;
  logic             push;

  lztbe_pkg::desc_t q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign d        = match_offset - 12'd1;
  assign l        = match_length - 16'd2;
  assign w        = {1'b0, l} + 17'd1;
  assign long_off = (d[11:7] != 5'd0);

  // position of the highest set bit of the gamma value
  always_comb begin
    n = 5'd0;
    for (int i = 1; i < 17; i++) begin
      if (w[i]) begin
        n = 5'(i);
      end
    end
  end

  always_comb begin
    dec          = '0;
    dec.off_hi   = d[10:7];
    dec.long_off = long_off;
    dec.val      = w[15:0];
    dec.n_zero   = (n == 5'd0);
    dec.nm1      = 4'(n - 5'd1);
    case (action)
      lztbe_pkg::ACT_LITERAL: begin
        dec.kind  = lztbe_pkg::K_LIT;
        dec.data  = literal_byte;
        dec.total = 6'd1;
      end
      lztbe_pkg::ACT_MATCH: begin
        dec.kind  = lztbe_pkg::K_MATCH;
        dec.data  = long_off ? {1'b1, d[6:0]} : d[7:0];
        dec.total = 6'd2 + {n, 1'b0} + (long_off ? 6'd4 : 6'd0);
      end
      default: begin
        dec.kind  = lztbe_pkg::K_FIN;
        dec.data  = 8'd0;
        dec.total = lztbe_pkg::FIN_TOTAL;
      end
    endcase
  end

  assign in_stall = (count == 2'd2);
  // the unused action code is taken and dropped
  assign push     = in_valid && !in_stall && (action != lztbe_pkg::ACT_UNUSED);
  assign q_valid  = (count != 2'd0);
  assign q_head   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= dec;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/lztbe_back.sv
`include "lz_token_bitstream_encoder_assert.svh"

module lztbe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  lztbe_pkg::desc_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             stream_end
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_REL
  } state_t;

  typedef enum logic [2:0] {
    P_FIRST,
    P_OFFS,
    P_ONES,
    P_ZERO,
    P_VAL,
    P_FONES,
    P_FZERO
  } phase_t;

  state_t           state;
  phase_t           phase;
  lztbe_pkg::desc_t cur;
  logic [3:0]       cnt;
  logic [5:0]       rem;
  logic [7:0]       flag_bits;
  logic [3:0]       fc;
  logic [3:0]       hc;
  logic [7:0]       held [lztbe_pkg::HELD_DEPTH];
  logic [3:0]       ri;
  logic             rel_flush;
  logic             rel_tok_last;

  logic             bit_val;
  logic             can_emit;
  logic             rel_done;
  logic [2:0]       rd_idx;
  logic [7:0]       flag_out;

  always_comb begin
    case (phase)
      P_FIRST: bit_val = (cur.kind != lztbe_pkg::K_LIT);
      P_OFFS:  bit_val = cur.off_hi[cnt[1:0]];
      P_ONES:  bit_val = 1'b1;
      P_ZERO:  bit_val = 1'b0;
      P_VAL:   bit_val = cur.val[cnt];
      P_FONES: bit_val = 1'b1;
      P_FZERO: bit_val = 1'b0;
      default: bit_val = 1'b0;
    endcase
  end

  assign pop      = (state == S_IDLE) && q_valid;
  assign can_emit = !out_valid || !out_stall;
  assign rel_done = (ri == hc);
  assign rd_idx   = 3'(ri - 4'd1);
  // final partial flag byte goes out left-aligned
  assign flag_out = rel_flush ? (flag_bits << (4'd8 - fc)) : flag_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_FIRST;
      fc         <= 4'd0;
      hc         <= 4'd0;
      flag_bits  <= 8'd0;
      out_valid  <= 1'b0;
      run_last   <= 1'b0;
      stream_end <= 1'b0;
    end else begin
      // in release the next byte takes over the output register instead
      if (out_valid && !out_stall && (state != S_REL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_head;
            rem   <= q_head.total;
            phase <= P_FIRST;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (fc == 4'd8) begin
            // full flag byte waits for the ninth bit before it goes out
            state        <= S_REL;
            ri           <= 4'd0;
            rel_flush    <= 1'b0;
            rel_tok_last <= (cur.kind != lztbe_pkg::K_FIN) && (rem <= 6'd8);
          end else begin
            flag_bits <= {flag_bits[6:0], bit_val};
            fc        <= fc + 4'd1;
            rem       <= rem - 6'd1;
            if (phase == P_FIRST) begin
              held[hc[2:0]] <= cur.data;
              hc            <= hc + 4'd1;
            end
            case (phase)
              P_FIRST: begin
                if (cur.kind == lztbe_pkg::K_FIN) begin
                  phase <= P_FONES;
                  cnt   <= lztbe_pkg::FIN_ONES_LAST;
                end else if (cur.long_off) begin
                  phase <= P_OFFS;
                  cnt   <= 4'd3;
                end else begin
                  phase <= cur.n_zero ? P_ZERO : P_ONES;
                  cnt   <= cur.nm1;
                end
              end
              P_OFFS: begin
                if (cnt == 4'd0) begin
                  phase <= cur.n_zero ? P_ZERO : P_ONES;
                  cnt   <= cur.nm1;
                end else begin
                  cnt <= cnt - 4'd1;
                end
              end
              P_ONES: begin
                if (cnt == 4'd0) begin
                  phase <= P_ZERO;
                end else begin
                  cnt <= cnt - 4'd1;
                end
              end
              P_ZERO: begin
                phase <= P_VAL;
                cnt   <= cur.nm1;
              end
              P_VAL: begin
                cnt <= cnt - 4'd1;
              end
              P_FONES: begin
                if (cnt == 4'd0) begin
                  phase <= P_FZERO;
                end else begin
                  cnt <= cnt - 4'd1;
                end
              end
              default: begin
                phase <= P_FZERO;
              end
            endcase
            if (rem == 6'd1) begin
              if (cur.kind == lztbe_pkg::K_FIN) begin
                state        <= S_REL;
                ri           <= 4'd0;
                rel_flush    <= 1'b1;
                rel_tok_last <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_REL: begin
          if (can_emit) begin
            out_valid  <= 1'b1;
            out_byte   <= (ri == 4'd0) ? flag_out : held[rd_idx];
            run_last   <= rel_done && rel_tok_last;
            stream_end <= rel_done && rel_flush;
            if (rel_done) begin
              fc <= 4'd0;
              hc <= 4'd0;
              if (rel_flush) begin
                flag_bits <= 8'd0;
                state     <= S_IDLE;
              end else begin
                state <= S_BIT;
              end
            end else begin
              ri <= ri + 4'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LZTBE_ASSERT_ALWAYS(a_fc_range, fc <= 4'd8, "flag bit count above eight")
  `LZTBE_ASSERT_ALWAYS(a_held_le_flags, hc <= fc, "more held bytes than flag bits")
  `LZTBE_ASSERT_IMPLY(a_rel_index, state == S_REL, ri <= hc, "release index past held bytes")
  `LZTBE_ASSERT_IMPLY(a_end_is_last, out_valid && stream_end, run_last,
                      "stream end without run last")

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_BYTES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = lztbe_pkg::ACT_LITERAL;
  logic [7:0]  literal_byte = '0;
  logic [11:0] match_offset = '0;
  logic [15:0] match_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        stream_end;

  lz_token_bitstream_encoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .literal_byte (literal_byte),
    .match_offset (match_offset),
    .match_length (match_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .stream_end   (stream_end)
  );

  always #1 clk = ~clk;

  // encoder state mirror
  logic [7:0]   grp_flags = '0;
  logic [3:0]   grp_nbits = '0;
  logic [7:0]   held_data [lztbe_pkg::HELD_DEPTH];
  logic [3:0]   held_n = '0;
  stream_byte_t token_bytes[$];
  stream_byte_t stream_due[$];

  int  n_fail = 0;
  int  quiet_cycles = 0;
  int  out_hold = 0;
  bit  idle_en = 1'b1;

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    stream_byte_t rec;
    rec.data = b;
    rec.last = 1'b0;
    rec.fin  = 1'b0;
    if (token_bytes.size() < MAX_BYTES) token_bytes.push_back(rec);
  endfunction

  function automatic void flush_group(logic [7:0] flag_byte);
    emit_byte(flag_byte);
    for (int i = 0; i < held_n && i < lztbe_pkg::HELD_DEPTH; i++) emit_byte(held_data[i]);
    held_n = '0;
  endfunction

  // a full flag byte waits until the ninth bit shows up
  function automatic void push_flag_bit(logic b);
    if (grp_nbits >= 4'd8) begin
      flush_group(grp_flags);
      grp_nbits = '0;
    end
    grp_flags = {grp_flags[6:0], b};
    grp_nbits = grp_nbits + 4'd1;
  endfunction

  function automatic void hold_byte(logic [7:0] b);
    if (held_n < lztbe_pkg::HELD_DEPTH) begin
      held_data[held_n[2:0]] = b;
      held_n = held_n + 4'd1;
    end
  endfunction

  function automatic void push_gamma(logic [15:0] v);
    logic [31:0] w;
    int n;
    w = {16'd0, v} + 32'd1;
    n = 0;
    while (n < 31 && (w >> (n + 1)) != 0) n++;
    for (int i = 0; i < n; i++) push_flag_bit(1'b1);
    push_flag_bit(1'b0);
    for (int i = n - 1; i >= 0; i--) push_flag_bit(w[i]);
  endfunction

  function automatic void encode_token(logic [1:0] act, logic [7:0] lit,
                                       logic [11:0] offs, logic [15:0] len);
    logic [11:0] off_m1;
    logic [15:0] glen;
    logic [7:0]  tail_flags;
    token_bytes.delete();
    off_m1 = offs - 12'd1;
    glen = len - 16'd2;
    case (act)
      lztbe_pkg::ACT_LITERAL: begin
        push_flag_bit(1'b0);
        hold_byte(lit);
      end
      lztbe_pkg::ACT_MATCH: begin
        push_flag_bit(1'b1);
        if (off_m1 > 12'd127) begin
          hold_byte({1'b1, off_m1[6:0]});
          for (int i = 3; i >= 0; i--) push_flag_bit(off_m1[7 + i]);
        end else begin
          hold_byte(off_m1[7:0]);
        end
        push_gamma(glen);
      end
      lztbe_pkg::ACT_FINISH: begin
        push_flag_bit(1'b1);
        hold_byte(8'h00);
        for (int i = 0; i < 16; i++) push_flag_bit(1'b1);
        push_flag_bit(1'b0);
        if (grp_nbits > 0 && grp_nbits <= 8) begin
          tail_flags = grp_flags << (8 - grp_nbits);
          flush_group(tail_flags);
        end
        grp_flags = '0;
        grp_nbits = '0;
        held_n = '0;
        if (token_bytes.size() > 0) token_bytes[token_bytes.size() - 1].fin = 1'b1;
      end
      default: ;
    endcase
    if (token_bytes.size() > 0) token_bytes[token_bytes.size() - 1].last = 1'b1;
    foreach (token_bytes[i]) stream_due.push_back(token_bytes[i]);
  endfunction

  // enters and leaves at a falling edge
  task automatic send_token(logic [1:0] act, logic [7:0] lit,
                            logic [11:0] offs, logic [15:0] len);
    int gap;
    action <= act;
    literal_byte <= lit;
    match_offset <= offs;
    match_length <= len;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_token(act, lit, offs, len);
    @(negedge clk);
    gap = pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_token();
    logic [1:0]  act;
    logic [11:0] offs;
    logic [15:0] len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) act = lztbe_pkg::ACT_UNUSED;
    else if (r < 9) act = lztbe_pkg::ACT_FINISH;
    else if (r < 55) act = lztbe_pkg::ACT_LITERAL;
    else act = lztbe_pkg::ACT_MATCH;
    r = $urandom_range(0, 99);
    if (r < 5) offs = 12'($urandom);
    else if (r < 50) offs = 12'($urandom_range(1, 128));
    else offs = 12'($urandom_range(1, 2048));
    r = $urandom_range(0, 99);
    if (r < 60) len = 16'($urandom_range(2, 16));
    else if (r < 85) len = 16'($urandom_range(2, 300));
    else if (r < 95) len = 16'($urandom_range(2, 65535));
    else len = 16'($urandom);
    send_token(act, 8'($urandom), offs, len);
  endtask

  task automatic test_directed();
    send_token(lztbe_pkg::ACT_LITERAL, 8'h00, 12'd1, 16'd2);
    send_token(lztbe_pkg::ACT_LITERAL, 8'hFF, 12'hFFF, 16'hFFFF);
    send_token(lztbe_pkg::ACT_LITERAL, 8'hA5, 12'd5, 16'd5);
    send_token(lztbe_pkg::ACT_LITERAL, 8'h5A, 12'd5, 16'd5);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd1, 16'd2);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd128, 16'd3);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd129, 16'd2);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd2048, 16'd65535);
    // offset zero and offset beyond the window both wrap into long form
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd0, 16'd0);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd4095, 16'd1);
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd2049, 16'd257);
    send_token(lztbe_pkg::ACT_UNUSED, 8'hFF, 12'hFFF, 16'hFFFF);
    send_token(lztbe_pkg::ACT_FINISH, 8'h00, 12'd0, 16'd0);
    // finish on an empty stream
    send_token(lztbe_pkg::ACT_FINISH, 8'h00, 12'd0, 16'd0);
    // a full group of held literals released by a long match
    for (int i = 0; i < 8; i++) begin
      send_token(lztbe_pkg::ACT_LITERAL, 8'h11 * i[7:0], 12'd1, 16'd2);
    end
    send_token(lztbe_pkg::ACT_MATCH, 8'h00, 12'd1, 16'd65535);
    send_token(lztbe_pkg::ACT_FINISH, 8'h00, 12'd0, 16'd0);
  endtask

  task automatic test_random_tokens();
    for (int i = 0; i < 150; i++) send_random_token();
    send_token(lztbe_pkg::ACT_FINISH, 8'h00, 12'd0, 16'd0);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    for (int i = 0; i < 30; i++) send_random_token();
    send_token(lztbe_pkg::ACT_FINISH, 8'h00, 12'd0, 16'd0);
    idle_en = 1'b1;
  endtask

  always @(negedge clk) begin
    if (rst || out_hold == 0) begin
      out_stall <= 1'b0;
      out_hold <= rst ? 0 : pick_idle_len();
    end else begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end
  end

  always @(posedge clk) begin
    stream_byte_t exp_b;
    if (!rst && out_valid && !out_stall) begin
      if (stream_due.size() == 0) begin
        $error("unexpected output transfer: out_byte %02h", out_byte);
        n_fail++;
      end else begin
        exp_b = stream_due.pop_front();
        if (out_byte !== exp_b.data) begin
          $error("out_byte: expected %02h, got %02h", exp_b.data, out_byte);
          n_fail++;
        end
        if (run_last !== exp_b.last) begin
          $error("run_last: expected %0b, got %0b", exp_b.last, run_last);
          n_fail++;
        end
        if (stream_end !== exp_b.fin) begin
          $error("stream_end: expected %0b, got %0b", exp_b.fin, stream_end);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_tokens();
    test_back_to_back();
    in_valid <= 1'b0;
    while (stream_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0 && stream_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/lztbe_pkg.sv
design/lztbe_front.sv
design/lztbe_back.sv
design/lz_token_bitstream_encoder.sv
sim/tb_top.sv
